/* hdl/csln_pkg.sv */
// Shared types and constants for the comment-strip line normaliser.
`timescale 1ns / 1ps

package csln_pkg;

    // Bytes that steer the scanner
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // Most results one input byte can cause
    localparam int MAX_RES = 3;

    // Default depth of the queue between scanner and output sequencer
    localparam int QUEUE_DEPTH = 4;

    // Input request: one source byte
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } t_in_req;

    // Output request: one kept byte or one line end
    typedef struct packed {
        logic [7:0] char_out;
        logic       line_end;
        logic       last_of_run;
    } t_out_req;

    // All results of one input byte, slot 0 goes out first
    typedef struct packed {
        logic [1:0]                cnt;
        t_out_req [MAX_RES-1:0]    slot;
    } t_bundle;

    localparam int BUNDLE_W = $bits(t_bundle);

endpackage

/* hdl/comment_strip_line_normaliser_unit.sv */
// Top level of the comment-strip line normaliser.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+----------------------------------
//  input     | in        | push / full           | i_in_req  (char_in, end_of_text)
//  result    | out       | empty / pop           | o_out_req (char_out, line_end,
//            |           |                       |            last_of_run)
//
// One input byte is taken per cycle while the bundle queue has room; the scan
// mode updates in that same cycle. Each byte yields zero to three results,
// delivered one per cycle while pop is held, so the result port sets the
// long-run rate. Results are registered in the queue, then in the sequencer.
// Reset is synchronous and active low; it clears mode, queue and sequencer.
// A stalled pop backs up the queue, and full rises once QueueDepth bundles wait.
`timescale 1ns / 1ps

module comment_strip_line_normaliser_unit
    import csln_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_req  i_in_req,
    output logic     empty,
    input  logic     pop,
    output t_out_req o_out_req
);

    logic    w_accept;
    logic    w_q_push;
    t_bundle w_bun;
    logic    w_q_full;
    logic    w_q_nempty;
    logic    w_q_pop;
    t_bundle w_q_head;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    // Classify bytes and build result bundles
    csln_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_accept),
        .i_req    (i_in_req),
        .o_push   (w_q_push),
        .o_bundle (w_bun)
    );

    // Decouple scanner from output
    csln_queue #(
        .DEPTH (QueueDepth)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_q_push),
        .i_data   (w_bun),
        .i_pop    (w_q_pop),
        .o_head   (w_q_head),
        .o_full   (w_q_full),
        .o_nempty (w_q_nempty)
    );

    // Play bundles out one request at a time
    csln_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_nempty (w_q_nempty),
        .i_q_head   (w_q_head),
        .o_q_pop    (w_q_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_req      (o_out_req)
    );

`ifndef ASSERT_OFF
    // A line end request never carries a byte
    a_le_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_req.line_end) |-> (o_out_req.char_out == 8'h00))
        else $error("line end carries a nonzero byte");

    // Scanner only queues bundles that hold at least one result
    a_bundle_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> (w_bun.cnt != 2'd0))
        else $error("empty bundle queued");

    // Output stays empty while nothing is queued or arriving
    a_stay_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !w_q_nempty && !w_q_push) |=> empty)
        else $error("result appeared from nowhere");

    // Queue never takes a bundle while full
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_q_push)
        else $error("bundle pushed into full queue");
`endif

endmodule

/* hdl/csln_front.sv */
// Scanner: tracks comment mode and turns each byte into a bundle of results.
`timescale 1ns / 1ps

module csln_front
    import csln_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_in_req i_req,
    output logic    o_push,
    output t_bundle o_bundle
);

    typedef enum logic [4:0] {
        MODE_NORMAL     = 5'b00001,
        MODE_SLASH      = 5'b00010,
        MODE_BLOCK      = 5'b00100,
        MODE_BLOCK_STAR = 5'b01000,
        MODE_LINE       = 5'b10000
    } t_mode;

    // Candidate results in output order
    localparam int CAND_N = 5;
    localparam int C_PRE_SLASH = 0;
    localparam int C_CHAR      = 1;
    localparam int C_LE        = 2;
    localparam int C_EOT_SLASH = 3;
    localparam int C_EOT_LE    = 4;

    t_mode r_mode, n_mode;
    logic  r_lhc, n_lhc;

    logic [7:0]                c;
    logic                      is_nl, is_blank, is_slash, is_star;
    logic                      do_plain;
    logic [CAND_N-1:0]         flag;
    t_out_req [CAND_N-1:0]     cand;
    t_bundle                   bun;
    logic [1:0]                k;

    assign c        = i_req.char_in;
    assign is_nl    = (c == CHAR_NL);
    assign is_blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    assign is_slash = (c == CHAR_SLASH);
    assign is_star  = (c == CHAR_STAR);

    // Advance the scan mode and flag the results this byte causes
    always_comb begin
        n_mode   = r_mode;
        n_lhc    = r_lhc;
        flag     = '0;
        do_plain = 1'b0;

        case (r_mode)
            MODE_NORMAL: begin
                do_plain = 1'b1;
            end
            MODE_SLASH: begin
                if (is_star) begin
                    n_mode = MODE_BLOCK;
                end else if (is_slash) begin
                    n_mode = MODE_LINE;
                end else begin
                    flag[C_PRE_SLASH] = 1'b1;
                    n_lhc    = 1'b1;
                    n_mode   = MODE_NORMAL;
                    do_plain = 1'b1;
                end
            end
            MODE_BLOCK: begin
                if (is_star) begin
                    n_mode = MODE_BLOCK_STAR;
                end
            end
            MODE_BLOCK_STAR: begin
                if (is_slash) begin
                    n_mode = MODE_NORMAL;
                end else if (!is_star) begin
                    n_mode = MODE_BLOCK;
                end
            end
            MODE_LINE: begin
                if (is_nl) begin
                    n_mode   = MODE_NORMAL;
                    do_plain = 1'b1;
                end
            end
            default: begin
                n_mode   = MODE_NORMAL;
                do_plain = 1'b1;
            end
        endcase

        // Plain code byte: close line, drop blank, hold slash, or keep
        if (do_plain) begin
            if (is_nl) begin
                flag[C_LE] = n_lhc;
                n_lhc      = 1'b0;
            end else if (is_blank) begin
                n_lhc = n_lhc;
            end else if (is_slash) begin
                n_mode = MODE_SLASH;
            end else begin
                flag[C_CHAR] = 1'b1;
                n_lhc        = 1'b1;
            end
        end

        // End of text: flush held slash, close open line, return to reset state
        if (i_req.end_of_text) begin
            if (n_mode == MODE_SLASH) begin
                flag[C_EOT_SLASH] = 1'b1;
                n_lhc             = 1'b1;
            end
            flag[C_EOT_LE] = n_lhc;
            n_mode         = MODE_NORMAL;
            n_lhc          = 1'b0;
        end
    end

    // Candidate payloads
    always_comb begin
        cand = '0;
        cand[C_PRE_SLASH].char_out = CHAR_SLASH;
        cand[C_CHAR].char_out      = c;
        cand[C_LE].line_end        = 1'b1;
        cand[C_EOT_SLASH].char_out = CHAR_SLASH;
        cand[C_EOT_LE].line_end    = 1'b1;
    end

    // Pack flagged candidates into slots, mark the final one
    always_comb begin
        bun = '0;
        k   = '0;
        for (int i = 0; i < CAND_N; i++) begin
            if (flag[i] && (k != 2'd3)) begin
                bun.slot[k] = cand[i];
                k           = k + 2'd1;
            end
        end
        if (k != 2'd0) begin
            bun.slot[k - 2'd1].last_of_run = 1'b1;
        end
        bun.cnt = k;
    end

    assign o_push   = i_valid && (k != 2'd0);
    assign o_bundle = bun;

    // Hold mode state, update on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_lhc  <= 1'b0;
        end else if (i_valid) begin
            r_mode <= n_mode;
            r_lhc  <= n_lhc;
        end
    end

endmodule

/* hdl/csln_queue.sv */
// Short register queue of result bundles between scanner and sequencer.
`timescale 1ns / 1ps

module csln_queue
    import csln_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output t_bundle o_head,
    output logic    o_full,
    output logic    o_nempty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_bundle [DEPTH-1:0] r_mem;
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    logic do_push, do_pop;

    assign o_full   = (r_cnt == FULL_CNT);
    assign o_nempty = (r_cnt != '0);
    assign o_head   = r_mem[r_rd];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_nempty;

    // Store incoming bundle
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

/* hdl/csln_back.sv */
// Output sequencer: plays out one bundle slot per pop.
`timescale 1ns / 1ps

module csln_back
    import csln_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_nempty,
    input  t_bundle  i_q_head,
    output logic     o_q_pop,
    output logic     o_empty,
    input  logic     i_pop,
    output t_out_req o_req
);

    t_bundle    r_bun;
    logic       r_busy;
    logic [1:0] r_idx;

    logic last_slot, take;

    assign last_slot = r_busy && (r_idx == (r_bun.cnt - 2'd1));
    assign take      = i_pop && r_busy;
    assign o_q_pop   = i_q_nempty && (!r_busy || (take && last_slot));
    assign o_empty   = !r_busy;
    assign o_req     = r_bun.slot[r_idx];

    // Load next bundle from queue
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_bun <= i_q_head;
        end
    end

    // Step through slots, drop bundle after its final slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (last_slot) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

/* tb/comment_strip_line_normaliser_checker.sv */
// Checker that predicts the normalized output stream and compares it with the block.
`timescale 1ns / 1ps

module comment_strip_line_normaliser_checker
    import csln_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  logic     i_full,
    input  t_in_req  i_in_req,
    input  logic     i_empty,
    input  logic     i_pop,
    input  t_out_req i_out_req,
    output int       o_fail_cnt,
    output int       o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [2:0] {
        SCAN_CODE       = 3'd0,
        SCAN_SLASH      = 3'd1,
        SCAN_BLOCK      = 3'd2,
        SCAN_BLOCK_STAR = 3'd3,
        SCAN_LINE       = 3'd4
    } t_scan_mode;

    t_scan_mode scan_mode = SCAN_CODE;
    logic       line_open = 1'b0;
    t_out_req   byte_results[$];
    t_out_req   predicted_q[$];

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
    end

    function automatic logic is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // Append one result for the current byte, never more than the block can carry
    function automatic void add_result(input logic [7:0] ch, input logic le);
        t_out_req r;
        r.char_out    = ch;
        r.line_end    = le;
        r.last_of_run = 1'b0;
        if (byte_results.size() < MAX_RES) byte_results.insert(byte_results.size(), r);
    endfunction

    // Handle a byte seen in plain code
    function automatic void code_byte(input logic [7:0] c);
        if (c == CHAR_NL) begin
            if (line_open) add_result(8'h00, 1'b1);
            line_open = 1'b0;
        end else if (c == CHAR_SLASH) begin
            scan_mode = SCAN_SLASH;
        end else if (!is_blank(c)) begin
            add_result(c, 1'b0);
            line_open = 1'b1;
        end
    endfunction

    // Advance the scanner by one accepted request and queue what it yields
    function automatic void scan_source_byte(input t_in_req req);
        t_out_req r;
        byte_results.delete();
        case (scan_mode)
            SCAN_SLASH: begin
                if (req.char_in == CHAR_STAR) begin
                    scan_mode = SCAN_BLOCK;
                end else if (req.char_in == CHAR_SLASH) begin
                    scan_mode = SCAN_LINE;
                end else begin
                    // flush the held slash, then treat the byte as code
                    add_result(CHAR_SLASH, 1'b0);
                    line_open = 1'b1;
                    scan_mode = SCAN_CODE;
                    code_byte(req.char_in);
                end
            end
            SCAN_BLOCK: begin
                if (req.char_in == CHAR_STAR) scan_mode = SCAN_BLOCK_STAR;
            end
            SCAN_BLOCK_STAR: begin
                if (req.char_in == CHAR_SLASH) scan_mode = SCAN_CODE;
                else if (req.char_in != CHAR_STAR) scan_mode = SCAN_BLOCK;
            end
            SCAN_LINE: begin
                if (req.char_in == CHAR_NL) begin
                    scan_mode = SCAN_CODE;
                    code_byte(req.char_in);
                end
            end
            default: begin
                scan_mode = SCAN_CODE;
                code_byte(req.char_in);
            end
        endcase

        // End of text: flush a held slash, close the line, drop any open comment
        if (req.end_of_text) begin
            if (scan_mode == SCAN_SLASH) begin
                add_result(CHAR_SLASH, 1'b0);
                line_open = 1'b1;
            end
            if (line_open) add_result(8'h00, 1'b1);
            scan_mode = SCAN_CODE;
            line_open = 1'b0;
        end

        if (byte_results.size() > 0) begin
            r = byte_results[byte_results.size() - 1];
            r.last_of_run = 1'b1;
            byte_results[byte_results.size() - 1] = r;
        end
        foreach (byte_results[i]) predicted_q.insert(predicted_q.size(), byte_results[i]);
    endfunction

    function automatic void note_failure(input string what, input t_out_req want,
                                         input t_out_req got);
        o_fail_cnt++;
        if (o_fail_cnt <= REPORT_LIMIT)
            $display("ERROR %0t: %s: expected char %02h line_end %0b last %0b, %s",
                     $time, what, want.char_out, want.line_end, want.last_of_run,
                     $sformatf("got char %02h line_end %0b last %0b",
                               got.char_out, got.line_end, got.last_of_run));
    endfunction

    // Compare one accepted result with the oldest prediction
    function automatic void check_result(input t_out_req got);
        t_out_req want;
        if (predicted_q.size() == 0) begin
            note_failure("result with nothing expected", '0, got);
        end else begin
            want = predicted_q.pop_front();
            if (got.char_out !== want.char_out || got.line_end !== want.line_end
                || got.last_of_run !== want.last_of_run)
                note_failure("field mismatch", want, got);
        end
    endfunction

    // Watch both channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_mode = SCAN_CODE;
            line_open = 1'b0;
        end else begin
            if (i_push && !i_full) scan_source_byte(i_in_req);
            if (i_pop && !i_empty) check_result(i_out_req);
        end
        o_pending = predicted_q.size();
    end

endmodule

/* tb/comment_strip_line_normaliser_unit_tb.sv */
// Testbench top: drives source text into the normaliser and gives the verdict.
`timescale 1ns / 1ps

module comment_strip_line_normaliser_unit_tb;
    import csln_pkg::*;

    localparam int RANDOM_BYTES = 500;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_START   = 150;
    localparam int HOLD_LEN     = 250;
    localparam int DRAIN_CYCLES = 10;

    typedef enum logic [1:0] {
        POP_ALL,
        POP_COIN,
        POP_QUARTER,
        POP_MOST
    } t_pop_style;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     push = 1'b0;
    logic     full;
    t_in_req  i_in_req = '0;
    logic     empty;
    logic     pop = 1'b0;
    t_out_req o_out_req;
    int       fail_cnt;
    int       pending;
    int       stall_cnt = 0;
    t_in_req  source_q[$];

    always #4 i_clk = ~i_clk;

    comment_strip_line_normaliser_unit uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_req  (i_in_req),
        .empty     (empty),
        .pop       (pop),
        .o_out_req (o_out_req)
    );

    comment_strip_line_normaliser_checker result_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_in_req   (i_in_req),
        .i_empty    (empty),
        .i_pop      (pop),
        .i_out_req  (o_out_req),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    task automatic add_byte(input logic [7:0] c, input logic eot);
        t_in_req r;
        r.char_in     = c;
        r.end_of_text = eot;
        source_q.insert(source_q.size(), r);
    endtask

    task automatic add_text(input string s, input logic eot_last);
        for (int i = 0; i < s.len(); i++) add_byte(s[i], eot_last && i == s.len() - 1);
    endtask

    function automatic logic maybe_end();
        return $urandom_range(0, 79) == 0;
    endfunction

    // Any byte that is neither whitespace nor a slash
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                           : $urandom_range(33, 126));
        while (c == CHAR_SLASH || c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        int pick;
        pick = $urandom_range(0, 5);
        return (pick == 5) ? CHAR_SPACE : CHAR_TAB + 8'(pick);
    endfunction

    // Comment bodies lean on the bytes that steer the scanner
    function automatic logic [7:0] comment_char();
        int pick;
        pick = $urandom_range(0, 6);
        case (pick)
            0: return CHAR_STAR;
            1: return CHAR_SLASH;
            2: return CHAR_NL;
            3: return CHAR_SPACE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Append one random token: code, whitespace, comments, or noise
    task automatic add_random_token();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        n    = $urandom_range(0, 6);
        if (kind < 35) begin
            repeat (n + 1) add_byte(plain_char(), maybe_end());
        end else if (kind < 48) begin
            add_byte(blank_char(), maybe_end());
        end else if (kind < 58) begin
            add_byte(CHAR_NL, maybe_end());
        end else if (kind < 70) begin
            // block comment, now and then left unclosed
            add_byte(CHAR_SLASH, maybe_end());
            add_byte(CHAR_STAR, maybe_end());
            repeat (n) add_byte(comment_char(), maybe_end());
            if ($urandom_range(0, 7) != 0) begin
                if ($urandom_range(0, 2) == 0) add_byte(CHAR_STAR, maybe_end());
                add_byte(CHAR_STAR, maybe_end());
                add_byte(CHAR_SLASH, maybe_end());
            end
        end else if (kind < 80) begin
            add_byte(CHAR_SLASH, maybe_end());
            add_byte(CHAR_SLASH, maybe_end());
            repeat (n) add_byte(comment_char(), maybe_end());
            add_byte(CHAR_NL, maybe_end());
        end else if (kind < 88) begin
            // lone slash followed by a newline, a blank or any other non-slash byte
            add_byte(CHAR_SLASH, maybe_end());
            case ($urandom_range(0, 2))
                0: add_byte(CHAR_NL, maybe_end());
                1: add_byte(blank_char(), maybe_end());
                default: add_byte(plain_char(), maybe_end());
            endcase
        end else if (kind < 93) begin
            add_byte(CHAR_STAR, maybe_end());
            if ($urandom_range(0, 1) == 0) add_byte(CHAR_SLASH, maybe_end());
        end else begin
            add_byte(8'($urandom_range(0, 255)), maybe_end());
        end
    endtask

    // Build the text, reset, then send requests in bursts
    initial begin
        int n_directed;
        int idx;
        int burst_len;
        int gap_len;

        // extremes, whitespace, held slash flushed by a byte and by a newline
        add_byte(8'h00, 1'b0);
        add_byte(CHAR_TAB, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(CHAR_CR, 1'b0);
        add_byte(8'h0B, 1'b0);
        add_text("/a/\n", 1'b0);
        // block comment that does not close on its own opener, joined lines
        add_text("/*/ \n**/b", 1'b0);
        add_byte(8'h0C, 1'b0);
        // line comment holding a block opener, newline kept
        add_text("///*\n", 1'b0);
        // end of text on a held slash, in a block, in a line comment, on a blank line
        add_text("c/", 1'b1);
        add_text("/*", 1'b1);
        add_text("//x", 1'b1);
        add_text(" ", 1'b1);
        n_directed = source_q.size();
        while (source_q.size() < n_directed + RANDOM_BYTES) add_random_token();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idx = 0;
        while (idx < source_q.size()) begin
            burst_len = $urandom_range(1, 24);
            while (burst_len > 0 && idx < source_q.size()) begin
                push     <= 1'b1;
                i_in_req <= source_q[idx];
                @(posedge i_clk);
                while (full) @(posedge i_clk);
                idx++;
                burst_len--;
            end
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_len > 0) begin
                push     <= 1'b0;
                i_in_req <= t_in_req'($bits(t_in_req)'(
                                $urandom_range(0, (1 << $bits(t_in_req)) - 1)));
                repeat (gap_len) @(posedge i_clk);
            end
        end
        push <= 1'b0;

        // drain the results still owed, then let the pipeline settle
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Stall the result side on a rotating pattern, with one long hold-off
    initial begin
        int         rx_cycle;
        t_pop_style style;
        rx_cycle = 0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            style = t_pop_style'((rx_cycle / 48) % 4);
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
                pop <= 1'b0;
            end else begin
                case (style)
                    POP_ALL:     pop <= 1'b1;
                    POP_COIN:    pop <= 1'($urandom_range(0, 1));
                    POP_QUARTER: pop <= (rx_cycle % 4 == 0);
                    default:     pop <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
